// ----- design/ssg_pkg.sv -----
// Shared types, constants and sine table functions for the sine sweep generator.
package ssg_pkg;

   localparam int DEF_PHASE_BITS      = 48;
   localparam int DEF_SINE_TABLE_BITS = 10;
   localparam int DEF_SAMPLE_BITS     = 16;

   localparam int CNT_W  = 24;
   localparam int INC_W  = 48;
   localparam int RAT_W  = 32;
   localparam int AMP_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_LENGTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INCREMENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT_DELTA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT_RATIO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE       = 3'd5;

   localparam logic             MODE_LINEAR      = 1'b0;
   localparam logic [CNT_W-1:0] RST_SWEEP_LENGTH = 24'd19200;
   localparam logic [RAT_W-1:0] RST_RATIO        = 32'h4000_0000;
   localparam logic [AMP_W-1:0] RST_AMPLITUDE    = 16'h8000;

   typedef struct packed {
      logic                    sweep_mode;
      logic [CNT_W-1:0]        sweep_length;
      logic [INC_W-1:0]        start_increment;
      logic signed [INC_W-1:0] increment_delta;
      logic [RAT_W-1:0]        increment_ratio;
      logic [AMP_W-1:0]        amplitude;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] sample_index;
      logic             last;
      logic             ended;
   } status_type;

   function automatic longint mul_q30(longint a, longint b);
      logic   neg;
      longint m;
      longint r;
      neg = (a < 0);
      m = neg ? -a : a;
      r = (m * b) >>> 30;
      return neg ? -r : r;
   endfunction

   function automatic int sine_entry(int k, int qbits, int sbits);
      longint x;
      longint x2;
      longint p;
      longint fs;
      longint v;
      x  = longint'(k) <<< (30 - qbits);
      x2 = mul_q30(x, x);
      p  = -64'sd3864;
      p  = 64'sd172272 + mul_q30(p, x2);
      p  = -64'sd5026995 + mul_q30(p, x2);
      p  = 64'sd85569306 + mul_q30(p, x2);
      p  = -64'sd693598669 + mul_q30(p, x2);
      p  = 64'sd1686629713 + mul_q30(p, x2);
      p  = mul_q30(p, x);
      if (p < 0) p = 0;
      if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
      fs = (64'sd1 <<< (sbits - 1)) - 1;
      v  = (p * fs + (64'sd1 <<< 29)) >>> 30;
      return int'(v);
   endfunction

endpackage

// ----- design/ssg_sine_lut.sv -----
// Quarter-wave sine lookup with mirroring and Q1.15 amplitude scaling.
module ssg_sine_lut #(
   parameter int SINE_TABLE_BITS = ssg_pkg::DEF_SINE_TABLE_BITS,
   parameter int SAMPLE_BITS     = ssg_pkg::DEF_SAMPLE_BITS
) (
   input  logic [SINE_TABLE_BITS-1:0]   table_index,
   input  logic [ssg_pkg::AMP_W-1:0]    amplitude,
   output logic signed [SAMPLE_BITS-1:0] sample
);
   import ssg_pkg::*;

   localparam int QBITS   = SINE_TABLE_BITS - 2;
   localparam int QUARTER = 1 << QBITS;
   localparam int MAGW    = SAMPLE_BITS - 1;
   localparam int PRODW   = MAGW + AMP_W + 1;
   localparam logic [QBITS:0]    QUARTER_K = (QBITS+1)'(QUARTER);
   localparam logic [MAGW-1:0]   PEAK      = MAGW'(sine_entry(QUARTER, QBITS, SAMPLE_BITS));
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

   logic [MAGW-1:0]        qtab [QUARTER];
   logic [1:0]             quadrant;
   logic [QBITS-1:0]       offset;
   logic [QBITS:0]         k;
   logic [MAGW-1:0]        mag;
   logic                   neg;
   logic [PRODW-1:0]       prod;
   logic [PRODW-16:0]      rounded;
   logic [SAMPLE_BITS-1:0] limit;
   logic [SAMPLE_BITS-1:0] clipped;

   for (genvar i = 0; i < QUARTER; i++) begin : g_tab
      assign qtab[i] = MAGW'(sine_entry(i, QBITS, SAMPLE_BITS));
   end

   always_comb begin
      quadrant = table_index[SINE_TABLE_BITS-1 -: 2];
      offset   = table_index[QBITS-1:0];
      k        = quadrant[0] ? (QUARTER_K - {1'b0, offset}) : {1'b0, offset};
      mag      = k[QBITS] ? PEAK : qtab[k[QBITS-1:0]];
      neg      = quadrant[1];
      prod     = PRODW'(mag) * PRODW'(amplitude);
      prod     = prod + PRODW'(16384);
      rounded  = prod[PRODW-1:15];
      limit    = neg ? (FULL_SCALE + SAMPLE_BITS'(1)) : FULL_SCALE;
      if (rounded > (PRODW-15)'(limit)) begin
         clipped = limit;
      end else begin
         clipped = rounded[SAMPLE_BITS-1:0];
      end
      sample = neg ? signed'(-clipped) : signed'(clipped);
   end

endmodule

// ----- design/ssg_sweep_state.sv -----
// Phase accumulator, phase increment and sample counter of the sweep.
module ssg_sweep_state #(
   parameter int PHASE_BITS = ssg_pkg::DEF_PHASE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   restart,
   input  ssg_pkg::cfg_type       cfg,
   output logic [PHASE_BITS-1:0]  phase,
   output ssg_pkg::status_type    status
);
   import ssg_pkg::*;

   localparam int LW = ((PHASE_BITS > INC_W) ? PHASE_BITS : INC_W) + 2;
   localparam logic [PHASE_BITS-1:0] PMASK = '1;

   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic [PHASE_BITS-1:0] inc_ff, inc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [PHASE_BITS-1:0] acc_e;
   logic [PHASE_BITS-1:0] inc_e;
   logic [CNT_W-1:0]      cnt_e;
   logic [63:0]           start64;
   logic [63:0]           incx;
   logic                  ended;
   logic signed [LW-1:0]  lin_sum;
   logic [PHASE_BITS-1:0] lin_next;
   logic [63:0]           prod_hi;
   logic [63:0]           prod_lo;
   logic [66:0]           exp_sum;
   logic [PHASE_BITS-1:0] exp_next;
   logic [PHASE_BITS-1:0] inc_next;

   always_comb begin
      start64 = 64'(cfg.start_increment);
      acc_e   = restart ? '0 : acc_ff;
      inc_e   = restart ? start64[PHASE_BITS-1:0] : inc_ff;
      cnt_e   = restart ? '0 : cnt_ff;
      ended   = (cnt_e >= cfg.sweep_length);

      lin_sum = LW'(signed'({1'b0, inc_e})) + LW'(signed'(cfg.increment_delta));
      if (lin_sum < 0) begin
         lin_next = '0;
      end else if (lin_sum[LW-1:PHASE_BITS] != '0) begin
         lin_next = PMASK;
      end else begin
         lin_next = lin_sum[PHASE_BITS-1:0];
      end

      incx    = 64'(inc_e);
      prod_hi = 64'(incx[63:32]) * 64'(cfg.increment_ratio);
      prod_lo = 64'(incx[31:0]) * 64'(cfg.increment_ratio);
      exp_sum = {1'b0, prod_hi, 2'b00} + 67'(prod_lo[63:30]);
      if (exp_sum[66:PHASE_BITS] != '0) begin
         exp_next = PMASK;
      end else begin
         exp_next = exp_sum[PHASE_BITS-1:0];
      end

      inc_next = (cfg.sweep_mode == MODE_LINEAR) ? lin_next : exp_next;

      acc_in = ended ? acc_e : acc_e + inc_e;
      inc_in = ended ? inc_e : inc_next;
      cnt_in = ended ? cnt_e : cnt_e + CNT_W'(1);

      phase               = acc_e;
      status.sample_index = cnt_e;
      status.last         = (({1'b0, cnt_e} + (CNT_W+1)'(1)) == {1'b0, cfg.sweep_length});
      status.ended        = ended;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         inc_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_in;
         inc_ff <= inc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- design/sine_sweep_generator_unit.sv -----
// Top level of the linear and exponential sine sweep generator.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_restart
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_sample, rsp_sample_index, rsp_last,
//          |           |                      | rsp_done_res
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One sample per cycle unless stalled; requests pass input, then response register.
// The sweep state updates as a transaction leaves the input register; the phase
// update, increment multiply and table read plus amplitude multiply sit in that cycle.
// Synchronous reset clears the sweep state, both pipeline valids and the config registers.
// A stalled response holds its register while the input register keeps one more
// transaction; csr_ready is always high.
module sine_sweep_generator_unit #(
   parameter int PHASE_BITS      = ssg_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = ssg_pkg::DEF_SINE_TABLE_BITS,
   parameter int SAMPLE_BITS     = ssg_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_sample,
   output logic [ssg_pkg::CNT_W-1:0]         rsp_sample_index,
   output logic                              rsp_last,
   output logic                              rsp_done_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssg_pkg::CSR_DAT_W-1:0]     csr_data
);
   import ssg_pkg::*;

   cfg_type cfg_ff;

   logic s1_valid_ff;
   logic s1_restart_ff;
   logic rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [CNT_W-1:0] rsp_index_ff;
   logic rsp_last_ff;
   logic rsp_done_ff;

   logic out_free;
   logic fire;
   logic req_take;
   logic [PHASE_BITS-1:0] phase;
   status_type status;
   logic signed [SAMPLE_BITS-1:0] sample;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sweep_mode      <= MODE_LINEAR;
         cfg_ff.sweep_length    <= RST_SWEEP_LENGTH;
         cfg_ff.start_increment <= '0;
         cfg_ff.increment_delta <= '0;
         cfg_ff.increment_ratio <= RST_RATIO;
         cfg_ff.amplitude       <= RST_AMPLITUDE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SWEEP_MODE:      cfg_ff.sweep_mode      <= csr_data[0];
            CSR_SWEEP_LENGTH:    cfg_ff.sweep_length    <= csr_data[CNT_W-1:0];
            CSR_START_INCREMENT: cfg_ff.start_increment <= csr_data[INC_W-1:0];
            CSR_INCREMENT_DELTA: cfg_ff.increment_delta <= signed'(csr_data[INC_W-1:0]);
            CSR_INCREMENT_RATIO: cfg_ff.increment_ratio <= csr_data[RAT_W-1:0];
            CSR_AMPLITUDE:       cfg_ff.amplitude       <= csr_data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_restart_ff <= req_restart;
      end
   end

   ssg_sweep_state #(
      .PHASE_BITS(PHASE_BITS)
   ) u_state (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .restart (s1_restart_ff),
      .cfg     (cfg_ff),
      .phase   (phase),
      .status  (status)
   );

   ssg_sine_lut #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_lut (
      .table_index (phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
      .amplitude   (cfg_ff.amplitude),
      .sample      (sample)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (status.ended) begin
            rsp_sample_ff <= '0;
            rsp_index_ff  <= '0;
            rsp_last_ff   <= 1'b0;
            rsp_done_ff   <= 1'b1;
         end else begin
            rsp_sample_ff <= sample;
            rsp_index_ff  <= status.sample_index;
            rsp_last_ff   <= status.last;
            rsp_done_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_sample_index = rsp_index_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

// ----- design/ssg_checker.sv -----
// Port-level checks for the sine sweep generator, bound to the top level.
module ssg_checker #(
   parameter int SAMPLE_BITS = ssg_pkg::DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_restart,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input logic [ssg_pkg::CNT_W-1:0]     rsp_sample_index,
   input logic                          rsp_last,
   input logic                          rsp_done_res,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [ssg_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ssg_pkg::CSR_DAT_W-1:0] csr_data
);

   // hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
         && $stable(rsp_sample_index) && $stable(rsp_last) && $stable(rsp_done_res))
      else $error("stalled response changed");

   // drop all sample content once the sweep has ended
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_sample == '0 && rsp_sample_index == '0 && !rsp_last)
      else $error("done response carries sample content");

   // clear pending responses on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sine_sweep_generator_unit ssg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

// ----- test/tb_sine_sweep_generator_unit.sv -----
// Self-checking testbench for the sine sweep generator: predicts every sample and checks it.
module tb_sine_sweep_generator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ssg_pkg::*;

   localparam int SAMPLE_W       = DEF_SAMPLE_BITS;
   localparam int LUT_BITS       = DEF_SINE_TABLE_BITS;
   localparam int LUT_SIZE       = 1 << LUT_BITS;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int IDLE_PERCENT   = 21;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 105;

   localparam logic [INC_W-1:0]     PHASE_MASK     = '1;
   localparam logic                 MODE_EXPONENT  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI   = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [CNT_W-1:0]           index;
      logic                       last;
      logic                       done;
   } sweep_sample_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_restart;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic [CNT_W-1:0]           rsp_sample_index;
   logic                       rsp_last;
   logic                       rsp_done_res;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DAT_W-1:0]       csr_data;

   sweep_sample_type expected_samples[$];
   int              sine_lut[LUT_SIZE];
   cfg_type         sweep_cfg;
   logic [INC_W-1:0] phase_acc;
   logic [INC_W-1:0] phase_step;
   logic [CNT_W-1:0] tick_count;

   int  error_count;
   int  ticks_sent;
   int  samples_checked;
   int  settings_loaded;
   int  stall_cycles;
   int  hold_request;
   int  hold_left;
   bit  steady;

   sine_sweep_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last         (rsp_last),
      .rsp_done_res     (rsp_done_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic longint q30_mul(longint a, longint b);
      longint mag;
      mag = (a < 0) ? -a : a;
      mag = (mag * b) >>> 30;
      return (a < 0) ? -mag : mag;
   endfunction

   function automatic longint quarter_wave(longint x);
      longint xx;
      longint acc;
      xx  = q30_mul(x, x);
      acc = -3864;
      acc = 172272 + q30_mul(acc, xx);
      acc = -5026995 + q30_mul(acc, xx);
      acc = 85569306 + q30_mul(acc, xx);
      acc = -693598669 + q30_mul(acc, xx);
      acc = 1686629713 + q30_mul(acc, xx);
      acc = q30_mul(acc, x);
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      return acc;
   endfunction

   function automatic void build_sine_lut();
      int     quad;
      int     pos;
      int     k;
      longint v;
      for (int i = 0; i < LUT_SIZE; i++) begin
         quad = i / (LUT_SIZE / 4);
         pos  = i % (LUT_SIZE / 4);
         k    = quad[0] ? (LUT_SIZE / 4) - pos : pos;
         v    = quarter_wave(longint'(k) << (32 - LUT_BITS));
         v    = (v * ((longint'(1) << (SAMPLE_W - 1)) - 1) + (longint'(1) << 29)) >>> 30;
         sine_lut[i] = quad[1] ? -int'(v) : int'(v);
      end
   endfunction

   function automatic logic [INC_W-1:0] next_step(logic [INC_W-1:0] inc);
      logic [INC_W-1:0] delta;
      logic [63:0]      hi;
      logic [63:0]      lo;
      if (sweep_cfg.sweep_mode == MODE_LINEAR) begin
         delta = sweep_cfg.increment_delta;
         if (delta[INC_W-1]) begin
            delta = -delta;
            return (inc < delta) ? '0 : inc - delta;
         end
         return (inc > PHASE_MASK - delta) ? PHASE_MASK : inc + delta;
      end
      hi = 64'(inc[47:32]) * 64'(sweep_cfg.increment_ratio);
      lo = (64'(inc[31:0]) * 64'(sweep_cfg.increment_ratio)) >> 30;
      if (lo > 64'(PHASE_MASK) || hi > (64'(PHASE_MASK) - lo) / 4) return PHASE_MASK;
      return INC_W'(hi * 4 + lo);
   endfunction

   function automatic sweep_sample_type predict_tick(logic restart);
      sweep_sample_type r;
      longint        t;
      longint        mag;
      longint        lim;
      if (restart) begin
         phase_acc  = '0;
         phase_step = sweep_cfg.start_increment;
         tick_count = '0;
      end
      r = '0;
      if (tick_count >= sweep_cfg.sweep_length) begin
         r.done = 1'b1;
         return r;
      end
      t   = sine_lut[phase_acc[INC_W-1 -: LUT_BITS]];
      mag = (((t < 0) ? -t : t) * longint'(sweep_cfg.amplitude) + 16384) >>> 15;
      lim = (t < 0) ? (longint'(1) << (SAMPLE_W - 1)) : (longint'(1) << (SAMPLE_W - 1)) - 1;
      if (mag > lim) mag = lim;
      r.sample = (t < 0) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
      r.index  = tick_count;
      r.last   = ({1'b0, tick_count} + 25'd1) == {1'b0, sweep_cfg.sweep_length};
      phase_acc  = phase_acc + phase_step;
      phase_step = next_step(phase_step);
      tick_count = tick_count + 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      sweep_sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, index %0d", rsp_sample_index));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (rsp_sample !== want.sample)
               report_mismatch($sformatf("sample %0d, want %0d (index %0d)",
                                         rsp_sample, want.sample, want.index));
            if (rsp_sample_index !== want.index)
               report_mismatch($sformatf("sample_index %0d, want %0d",
                                         rsp_sample_index, want.index));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b (index %0d)",
                                         rsp_last, want.last, want.index));
            if (rsp_done_res !== want.done)
               report_mismatch($sformatf("done_res %0b, want %0b (index %0d)",
                                         rsp_done_res, want.done, want.index));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", stall_cycles);
         $display("[sine_sweep_generator_unit] ERROR");
         $finish;
      end
   end

   // Leaves req_valid high after acceptance; wait_idle drops it.
   task automatic send_tick(input logic restart);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(predict_tick(restart));
      ticks_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_sweep(input cfg_type c);
      wait_idle();
      write_register(CSR_SWEEP_MODE, CSR_DAT_W'(c.sweep_mode));
      write_register(CSR_SWEEP_LENGTH, CSR_DAT_W'(c.sweep_length));
      write_register(CSR_START_INCREMENT, c.start_increment);
      write_register(CSR_INCREMENT_DELTA, c.increment_delta);
      write_register(CSR_INCREMENT_RATIO, CSR_DAT_W'(c.increment_ratio));
      write_register(CSR_AMPLITUDE, CSR_DAT_W'(c.amplitude));
      csr_valid <= 1'b0;
      sweep_cfg = c;
      settings_loaded++;
      @(posedge clock);
   endtask

   function automatic cfg_type random_sweep_cfg();
      cfg_type c;
      c.sweep_mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0:       c.sweep_length = '1;
         1:       c.sweep_length = 1;
         2:       c.sweep_length = CNT_W'($urandom_range(60, 200));
         default: c.sweep_length = CNT_W'($urandom_range(2, 60));
      endcase
      c.start_increment = INC_W'({$urandom, $urandom}) >> $urandom_range(0, 14);
      case ($urandom_range(0, 5))
         0:       c.increment_delta = 48'sh7FFF_FFFF_FFFF;
         1:       c.increment_delta = 48'sh8000_0000_0000;
         default: c.increment_delta = $signed(INC_W'({$urandom, $urandom})) >>>
                                      $urandom_range(0, 16);
      endcase
      case ($urandom_range(0, 5))
         0:       c.increment_ratio = $urandom;
         1:       c.increment_ratio = $urandom_range(0, 3) == 0 ? '0 : '1;
         default: c.increment_ratio = RST_RATIO + $urandom_range(0, 1 << 27) - (1 << 26);
      endcase
      case ($urandom_range(0, 7))
         0:       c.amplitude = AMP_W'($urandom_range(32769, 65535));
         1:       c.amplitude = RST_AMPLITUDE;
         default: c.amplitude = AMP_W'($urandom_range(0, 32768));
      endcase
      return c;
   endfunction

   task automatic test_reset_state();
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();
      // spare indexes must leave the settings alone
      write_register(CSR_SPARE_LO, '1);
      write_register(CSR_SPARE_HI, '1);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_linear_extremes();
      cfg_type c;
      c.sweep_mode      = MODE_LINEAR;
      c.sweep_length    = 5;
      c.start_increment = 48'h4000_0000_0000;
      c.increment_delta = 48'sh7FFF_FFFF_FFFF;
      c.increment_ratio = RST_RATIO;
      c.amplitude       = '1;
      program_sweep(c);
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      c.sweep_length    = 3;
      c.start_increment = 48'h8000_0000_0000;
      c.increment_delta = 48'sh8000_0000_0000;
      c.increment_ratio = '0;
      c.amplitude       = '0;
      program_sweep(c);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
   endtask

   task automatic test_exponential_saturation();
      cfg_type c;
      c.sweep_mode      = MODE_EXPONENT;
      c.sweep_length    = 4;
      c.start_increment = 48'h2000_0000_0000;
      c.increment_delta = '0;
      c.increment_ratio = '1;
      c.amplitude       = RST_AMPLITUDE;
      program_sweep(c);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_sweep_end();
      cfg_type c;
      c.sweep_mode      = MODE_LINEAR;
      c.sweep_length    = 1;
      c.start_increment = '1;
      c.increment_delta = 48'sh1234_5678_9ABC;
      c.increment_ratio = RST_RATIO;
      c.amplitude       = 16'd32767;
      program_sweep(c);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      c.sweep_mode      = MODE_EXPONENT;
      c.sweep_length    = '0;
      c.increment_ratio = '0;
      program_sweep(c);
      send_tick(1'b1);
   endtask

   task automatic test_output_backpressure();
      program_sweep(random_sweep_cfg());
      steady       = 1'b1;
      hold_request = 200;
      send_tick(1'b1);
      repeat (40) send_tick($urandom_range(0, 99) < 5);
      steady = 1'b0;
   endtask

   task automatic test_drain_pause();
      program_sweep(random_sweep_cfg());
      send_tick(1'b1);
      repeat (30) send_tick($urandom_range(0, 99) < 5);
      wait_idle();
      repeat (30) send_tick($urandom_range(0, 99) < 5);
   endtask

   task automatic run_sweep_phase(input int budget);
      int run;
      if ($urandom_range(0, 9) != 0) begin
         send_tick(1'b1);
         budget--;
      end
      while (budget > 0) begin
         run = (sweep_cfg.sweep_length > 80) ? $urandom_range(20, 80)
                                            : int'(sweep_cfg.sweep_length) + $urandom_range(0, 3);
         for (int j = 0; j < run && budget > 0; j++) begin
            send_tick($urandom_range(0, 99) < 3);
            budget--;
         end
         if (budget > 0) begin
            send_tick(1'b1);
            budget--;
         end
      end
   endtask

   task automatic test_random_sweeps();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_sweep(random_sweep_cfg());
         steady = (p == RANDOM_PHASES / 2);
         run_sweep_phase(PHASE_ITEMS);
      end
      steady = 1'b0;
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_restart <= 1'b0;
      rsp_ready   <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      error_count     = 0;
      ticks_sent      = 0;
      samples_checked = 0;
      settings_loaded = 0;
      stall_cycles    = 0;
      hold_request    = 0;
      hold_left       = 0;
      steady          = 1'b0;
      build_sine_lut();
      sweep_cfg.sweep_mode      = MODE_LINEAR;
      sweep_cfg.sweep_length    = RST_SWEEP_LENGTH;
      sweep_cfg.start_increment = '0;
      sweep_cfg.increment_delta = '0;
      sweep_cfg.increment_ratio = RST_RATIO;
      sweep_cfg.amplitude       = RST_AMPLITUDE;
      phase_acc  = '0;
      phase_step = '0;
      tick_count = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_linear_extremes();
      test_exponential_saturation();
      test_sweep_end();
      test_output_backpressure();
      test_drain_pause();
      test_random_sweeps();

      wait_idle();
      repeat (10) @(posedge clock);
      $display("run covered %0d sample ticks and %0d checked results over %0d sweep settings",
               ticks_sent, samples_checked, settings_loaded);
      $display("linear and exponential sweeps, saturation, sweep end and restarts included");
      if (error_count == 0) begin
         $display("[sine_sweep_generator_unit] OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[sine_sweep_generator_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ssg_pkg.sv
design/ssg_sine_lut.sv
design/ssg_sweep_state.sv
design/sine_sweep_generator_unit.sv
design/ssg_checker.sv
test/tb_sine_sweep_generator_unit.sv
